FILE: rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// signal held while a condition is true at the previous edge
`define ASSERT_HOLD(label, clk, rst_n, cond, sig, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) cond |=> $stable(sig)) \
		else $error(msg);

`endif

FILE: rtl/vsag_pkg.sv
package vsag_pkg;

	localparam int VREG_BYTES = 16;
	localparam int VREG_LOG2 = $clog2(VREG_BYTES);

	localparam int ADDR_W = 64;
	localparam int DATA_W = 64;
	localparam int PADDR_W = 6;
	localparam int SIZE_W = 4;
	localparam int VL_W = 8;
	localparam int VREG_W = 5;
	localparam int ELEM_W = 7;
	localparam int STRIDE_W = 16;
	localparam int EMUL_W = 3;
	localparam int RIDX_W = 9;
	localparam int SHIFT_W = 3;

	localparam logic CMD_RESTART = 1'b0;
	localparam logic CMD_ELEMENT = 1'b1;

	typedef enum logic [2:0] {
		REG_BASE_ADDRESS = 3'd0,
		REG_ELEMENT_BYTES = 3'd1,
		REG_VECTOR_LENGTH = 3'd2,
		REG_FIRST_REGISTER = 3'd3,
		REG_START_ELEMENT = 3'd4,
		REG_UNMASKED = 3'd5,
		REG_STRIDE = 3'd6,
		REG_EMUL_LOG2 = 3'd7
	} reg_idx_t;

endpackage

FILE: rtl/vector_strided_element_address_gen.sv
// Vector strided element address generator.
// Set up through the APB-style port while idle: base address, element size,
// vector length, first register, start element, mask mode, stride, emul.
// Registers sit at byte address 8*i, pready is always high.
// The command channel (command, mask_bit) takes a restart or an element
// command; each command gives exactly one result on the result channel
// (mem_address, reg_byte_index, byte_count, active, element_index, finished).
// A transfer on the command channel shows its result
// at the next edge from the result register.
// Throughput is one command per cycle while the receiver keeps up; the walk state and the single result
// register are updated together, and the 64-bit address add sets the path.
// While the receiver stalls the result register holds and cmd_ready drops;
// a command is still taken in the cycle the held result is transferred.
// Reset clears the walk state and the result register and loads the
// register defaults (element size 1, unmasked, unit stride).
module vector_strided_element_address_gen (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [vsag_pkg::PADDR_W-1:0]  paddr,
	input  logic [vsag_pkg::DATA_W-1:0]   pwdata,
	output logic [vsag_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	input  logic                          cmd_valid,
	output logic                          cmd_ready,
	input  logic                          command,
	input  logic                          mask_bit,
	output logic                          res_valid,
	input  logic                          res_ready,
	output logic [vsag_pkg::ADDR_W-1:0]   mem_address,
	output logic [vsag_pkg::RIDX_W-1:0]   reg_byte_index,
	output logic [vsag_pkg::SIZE_W-1:0]   byte_count,
	output logic                          active,
	output logic [vsag_pkg::ELEM_W-1:0]   element_index,
	output logic                          finished
);

	logic [vsag_pkg::ADDR_W-1:0]   base_address_q;
	logic [vsag_pkg::SIZE_W-1:0]   element_bytes_q;
	logic [vsag_pkg::VL_W-1:0]     vector_length_q;
	logic [vsag_pkg::VREG_W-1:0]   first_register_q;
	logic [vsag_pkg::ELEM_W-1:0]   start_element_q;
	logic                          unmasked_q;
	logic [vsag_pkg::STRIDE_W-1:0] stride_q;
	logic [vsag_pkg::EMUL_W-1:0]   emul_log2_q;

	logic [vsag_pkg::VL_W-1:0]     elem_cnt_q;
	logic [vsag_pkg::VREG_W-1:0]   reg_cnt_q;
	logic [vsag_pkg::ELEM_W-1:0]   slot_q;
	logic [vsag_pkg::ADDR_W-1:0]   run_addr_q;

	logic                          res_valid_q;
	logic [vsag_pkg::ADDR_W-1:0]   mem_address_q;
	logic [vsag_pkg::RIDX_W-1:0]   reg_byte_index_q;
	logic [vsag_pkg::SIZE_W-1:0]   byte_count_q;
	logic                          active_q;
	logic [vsag_pkg::ELEM_W-1:0]   element_index_q;
	logic                          finished_q;

	logic                          cfg_wr;
	vsag_pkg::reg_idx_t            cfg_idx;
	logic [1:0]                    size_log2;
	logic [vsag_pkg::SIZE_W-1:0]   size;
	logic [vsag_pkg::SHIFT_W-1:0]  emul_shift;
	logic [vsag_pkg::SHIFT_W:0]    shift_sum;
	logic [vsag_pkg::SHIFT_W-1:0]  epr_log2;
	logic [vsag_pkg::VL_W-1:0]     epr;
	logic [vsag_pkg::ADDR_W-1:0]   addr_step;
	logic                          cmd_xfer;
	logic                          restart;
	logic [vsag_pkg::VL_W-1:0]     v_cnt;
	logic [vsag_pkg::VREG_W-1:0]   v_reg;
	logic [vsag_pkg::ELEM_W-1:0]   v_slot;
	logic [vsag_pkg::ADDR_W-1:0]   v_addr;
	logic                          v_fin;
	logic                          advance;
	logic                          slot_wrap;
	logic [vsag_pkg::RIDX_W-1:0]   v_ridx;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;
	assign cfg_idx = vsag_pkg::reg_idx_t'(paddr[vsag_pkg::PADDR_W-1:3]);

	always_comb begin
		unique case (cfg_idx)
			vsag_pkg::REG_BASE_ADDRESS: prdata = base_address_q;
			vsag_pkg::REG_ELEMENT_BYTES: prdata = vsag_pkg::DATA_W'(element_bytes_q);
			vsag_pkg::REG_VECTOR_LENGTH: prdata = vsag_pkg::DATA_W'(vector_length_q);
			vsag_pkg::REG_FIRST_REGISTER: prdata = vsag_pkg::DATA_W'(first_register_q);
			vsag_pkg::REG_START_ELEMENT: prdata = vsag_pkg::DATA_W'(start_element_q);
			vsag_pkg::REG_UNMASKED: prdata = vsag_pkg::DATA_W'(unmasked_q);
			vsag_pkg::REG_STRIDE: prdata = vsag_pkg::DATA_W'(stride_q);
			vsag_pkg::REG_EMUL_LOG2: prdata = vsag_pkg::DATA_W'(emul_log2_q);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_address_q <= '0;
			element_bytes_q <= vsag_pkg::SIZE_W'(1);
			vector_length_q <= '0;
			first_register_q <= '0;
			start_element_q <= '0;
			unmasked_q <= 1'b1;
			stride_q <= '0;
			emul_log2_q <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				vsag_pkg::REG_BASE_ADDRESS: base_address_q <= pwdata;
				vsag_pkg::REG_ELEMENT_BYTES: element_bytes_q <= pwdata[vsag_pkg::SIZE_W-1:0];
				vsag_pkg::REG_VECTOR_LENGTH: vector_length_q <= pwdata[vsag_pkg::VL_W-1:0];
				vsag_pkg::REG_FIRST_REGISTER: first_register_q <= pwdata[vsag_pkg::VREG_W-1:0];
				vsag_pkg::REG_START_ELEMENT: start_element_q <= pwdata[vsag_pkg::ELEM_W-1:0];
				vsag_pkg::REG_UNMASKED: unmasked_q <= pwdata[0];
				vsag_pkg::REG_STRIDE: stride_q <= pwdata[vsag_pkg::STRIDE_W-1:0];
				vsag_pkg::REG_EMUL_LOG2: emul_log2_q <= pwdata[vsag_pkg::EMUL_W-1:0];
			endcase
		end
	end

	// unsupported sizes act as one byte
	always_comb begin
		case (element_bytes_q)
			4'd2: size_log2 = 2'd1;
			4'd4: size_log2 = 2'd2;
			4'd8: size_log2 = 2'd3;
			default: size_log2 = 2'd0;
		endcase
	end

	assign size = vsag_pkg::SIZE_W'(1) << size_log2;

	// fractional emul shrinks the register share, pattern 100 shifts by four
	assign emul_shift = emul_log2_q[2] ? vsag_pkg::SHIFT_W'(4'd8 - {1'b0, emul_log2_q}) : '0;
	assign shift_sum = {1'b0, emul_shift} + {2'b00, size_log2};
	assign epr_log2 = (shift_sum >= (vsag_pkg::SHIFT_W+1)'(vsag_pkg::VREG_LOG2)) ? '0 :
		vsag_pkg::SHIFT_W'((vsag_pkg::SHIFT_W+1)'(vsag_pkg::VREG_LOG2) - shift_sum);
	assign epr = vsag_pkg::VL_W'(1) << epr_log2;

	assign addr_step = (stride_q == '0) ? vsag_pkg::ADDR_W'(size) :
		{{(vsag_pkg::ADDR_W-vsag_pkg::STRIDE_W){stride_q[vsag_pkg::STRIDE_W-1]}}, stride_q};

	assign cmd_ready = !res_valid_q || res_ready;
	assign cmd_xfer = cmd_valid && cmd_ready;
	assign restart = (command == vsag_pkg::CMD_RESTART);

	// state the result describes: restart values or the current walk
	always_comb begin
		if (restart) begin
			v_cnt = {1'b0, start_element_q};
			v_addr = base_address_q;
			v_reg = first_register_q + vsag_pkg::VREG_W'(start_element_q >> epr_log2);
			v_slot = start_element_q & vsag_pkg::ELEM_W'(epr - 1'b1);
		end else begin
			v_cnt = elem_cnt_q;
			v_addr = run_addr_q;
			v_reg = reg_cnt_q;
			v_slot = slot_q;
		end
	end

	assign v_fin = v_cnt >= vector_length_q;
	assign v_ridx = (vsag_pkg::RIDX_W'(v_reg) << vsag_pkg::VREG_LOG2)
		+ (vsag_pkg::RIDX_W'(v_slot) << size_log2);
	assign advance = !restart && !v_fin;
	assign slot_wrap = ({1'b0, slot_q} + 1'b1) >= epr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elem_cnt_q <= '0;
			reg_cnt_q <= '0;
			slot_q <= '0;
			run_addr_q <= '0;
		end else if (cmd_xfer) begin
			if (restart) begin
				elem_cnt_q <= v_cnt;
				reg_cnt_q <= v_reg;
				slot_q <= v_slot;
				run_addr_q <= v_addr;
			end else if (advance) begin
				elem_cnt_q <= elem_cnt_q + 1'b1;
				run_addr_q <= run_addr_q + addr_step;
				if (slot_wrap) begin
					slot_q <= '0;
					reg_cnt_q <= reg_cnt_q + 1'b1;
				end else begin
					slot_q <= slot_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd_xfer) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_address_q <= '0;
			reg_byte_index_q <= '0;
			byte_count_q <= '0;
			active_q <= 1'b0;
			element_index_q <= '0;
			finished_q <= 1'b0;
		end else if (cmd_xfer) begin
			mem_address_q <= v_addr;
			reg_byte_index_q <= v_ridx;
			byte_count_q <= size;
			active_q <= advance && (unmasked_q || mask_bit);
			element_index_q <= v_cnt[vsag_pkg::ELEM_W-1:0];
			finished_q <= v_fin;
		end
	end

	assign res_valid = res_valid_q;
	assign mem_address = mem_address_q;
	assign reg_byte_index = reg_byte_index_q;
	assign byte_count = byte_count_q;
	assign active = active_q;
	assign element_index = element_index_q;
	assign finished = finished_q;

endmodule

FILE: rtl/vsag_checker.sv
`include "assert_macros.svh"

module vsag_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          cmd_valid,
	input logic                          cmd_ready,
	input logic                          command,
	input logic                          res_valid,
	input logic                          res_ready,
	input logic [vsag_pkg::ADDR_W-1:0]   mem_address,
	input logic [vsag_pkg::SIZE_W-1:0]   byte_count,
	input logic                          active,
	input logic                          finished
);

	`ASSERT_CLK(a_restart_inactive, clk, arst_n,
		cmd_valid && cmd_ready && command == vsag_pkg::CMD_RESTART |=> res_valid && !active,
		"restart transfer must give an inactive result")

	`ASSERT_CLK(a_active_not_finished, clk, arst_n,
		res_valid && active |-> !finished,
		"active result past the vector length")

	`ASSERT_CLK(a_size_legal, clk, arst_n,
		res_valid |-> byte_count == 4'd1 || byte_count == 4'd2 || byte_count == 4'd4 ||
			byte_count == 4'd8,
		"byte count not a legal element size")

	`ASSERT_CLK(a_ready_when_empty, clk, arst_n,
		!res_valid |-> cmd_ready,
		"command channel blocked with no result pending")

	`ASSERT_HOLD(a_addr_hold, clk, arst_n, res_valid && !res_ready, mem_address,
		"address changed during a stalled transfer")

endmodule

bind vector_strided_element_address_gen vsag_checker u_vsag_checker (
	.clk(clk),
	.arst_n(arst_n),
	.cmd_valid(cmd_valid),
	.cmd_ready(cmd_ready),
	.command(command),
	.res_valid(res_valid),
	.res_ready(res_ready),
	.mem_address(mem_address),
	.byte_count(byte_count),
	.active(active),
	.finished(finished)
);

FILE: verif/tb.sv
`timescale 1ns / 100ps

module tb;
	import vsag_pkg::*;

	localparam int APB_SLOT_BYTES = 8;
	localparam int RAND_ITEMS = 1550;
	localparam int LONG_HOLD = 200;
	localparam int IDLE_LIMIT = 2000;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [RIDX_W-1:0] ridx;
		logic [SIZE_W-1:0] nbytes;
		logic act;
		logic [ELEM_W-1:0] elem;
		logic fin;
	} access_t;

	typedef struct packed {
		bit known;
		access_t r;
	} typed_t;

	typedef struct packed {
		bit is_write;
		reg_idx_t rsel;
		logic [63:0] value;
		logic cmd;
		logic mbit;
		bit known;
		access_t r;
	} plan_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;
	logic cmd_valid = 1'b0;
	logic cmd_ready;
	logic command = 1'b0;
	logic mask_bit = 1'b0;
	logic res_valid;
	logic res_ready = 1'b0;
	logic [ADDR_W-1:0] mem_address;
	logic [RIDX_W-1:0] reg_byte_index;
	logic [SIZE_W-1:0] byte_count;
	logic active;
	logic [ELEM_W-1:0] element_index;
	logic finished;

	vector_strided_element_address_gen DUT (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// block setup as seen on the bus
	logic [63:0] cfg_base = '0;
	logic [3:0] cfg_ebytes = 4'd1;
	logic [7:0] cfg_vl = '0;
	logic [4:0] cfg_freg = '0;
	logic [6:0] cfg_start = '0;
	logic cfg_unmasked = 1'b1;
	logic [15:0] cfg_stride = '0;
	logic [2:0] cfg_emul = '0;

	// element walk
	logic [7:0] walk_elem = '0;
	logic [4:0] walk_reg = '0;
	logic [6:0] walk_slot = '0;
	logic [63:0] walk_addr = '0;

	access_t access_due[$];
	typed_t known_access[$];

	int mismatches = 0;
	int commands_taken = 0;
	int results_seen = 0;
	int active_seen = 0;
	int finished_seen = 0;
	int reg_writes = 0;
	int hold_reqs = 0;
	int holds_done = 0;
	int rx_wait = 0;
	int rx_calm = 0;

	function automatic int unsigned elem_bytes_now();
		case (cfg_ebytes)
			4'd1, 4'd2, 4'd4, 4'd8: return cfg_ebytes;
			default: return 1;
		endcase
	endfunction

	function automatic int unsigned elems_per_reg();
		int unsigned vbytes, n;
		vbytes = VREG_BYTES;
		if (cfg_emul[2])
			vbytes = vbytes >> (8 - cfg_emul);
		n = vbytes / elem_bytes_now();
		return (n == 0) ? 1 : n;
	endfunction

	function automatic access_t describe(logic act, logic fin);
		access_t r;
		r.addr = walk_addr;
		r.ridx = RIDX_W'(walk_reg * VREG_BYTES + walk_slot * elem_bytes_now());
		r.nbytes = SIZE_W'(elem_bytes_now());
		r.act = act;
		r.elem = walk_elem[ELEM_W-1:0];
		r.fin = fin;
		return r;
	endfunction

	function automatic access_t walk_access(logic c, logic m);
		int unsigned epr;
		access_t r;
		epr = elems_per_reg();
		if (c == CMD_RESTART) begin
			walk_elem = {1'b0, cfg_start};
			walk_addr = cfg_base;
			walk_reg = 5'(cfg_freg + walk_elem / epr);
			walk_slot = 7'(walk_elem % epr);
			r = describe(1'b0, walk_elem >= cfg_vl);
		end else if (walk_elem >= cfg_vl) begin
			r = describe(1'b0, 1'b1);
		end else begin
			r = describe(cfg_unmasked || m, 1'b0);
			walk_elem = walk_elem + 8'd1;
			if (cfg_stride == '0)
				walk_addr = walk_addr + 64'(elem_bytes_now());
			else
				walk_addr = walk_addr + {{48{cfg_stride[15]}}, cfg_stride};
			if (walk_slot + 1 >= epr) begin
				walk_slot = '0;
				walk_reg = walk_reg + 5'd1;
			end else begin
				walk_slot = walk_slot + 7'd1;
			end
		end
		return r;
	endfunction

	always @(posedge clk) begin : predict
		typed_t t;
		access_t want;
		if (arst_n) begin
			if (psel && penable && pwrite && pready) begin
				reg_writes++;
				case (reg_idx_t'(3'(paddr / APB_SLOT_BYTES)))
					REG_BASE_ADDRESS: cfg_base = pwdata;
					REG_ELEMENT_BYTES: cfg_ebytes = pwdata[3:0];
					REG_VECTOR_LENGTH: cfg_vl = pwdata[7:0];
					REG_FIRST_REGISTER: cfg_freg = pwdata[4:0];
					REG_START_ELEMENT: cfg_start = pwdata[6:0];
					REG_UNMASKED: cfg_unmasked = pwdata[0];
					REG_STRIDE: cfg_stride = pwdata[15:0];
					REG_EMUL_LOG2: cfg_emul = pwdata[2:0];
				endcase
			end
			if (cmd_valid && cmd_ready) begin
				commands_taken++;
				want = walk_access(command, mask_bit);
				t = known_access.pop_front();
				access_due.push_back(t.known ? t.r : want);
			end
		end
	end

	always @(posedge clk) begin : result_check
		access_t got, want;
		if (arst_n && res_valid && res_ready) begin
			got = {mem_address, reg_byte_index, byte_count, active, element_index, finished};
			results_seen++;
			if (active)
				active_seen++;
			if (finished)
				finished_seen++;
			if (access_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result transfer with nothing pending, addr=%h", $realtime,
						mem_address);
			end else begin
				want = access_due.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("%0t: mismatch exp addr=%h ridx=%0d bytes=%0d act=%b elem=%0d fin=%b",
							$realtime, want.addr, want.ridx, want.nbytes, want.act, want.elem,
							want.fin);
						$display("%0t: mismatch got addr=%h ridx=%0d bytes=%0d act=%b elem=%0d fin=%b",
							$realtime, got.addr, got.ridx, got.nbytes, got.act, got.elem, got.fin);
					end
				end
			end
		end
	end

	// receiver side: random stalls, calm stretches and the long hold-off
	always @(posedge clk) begin : receiver
		int pick;
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else begin
			if (hold_reqs != holds_done) begin
				holds_done++;
				rx_wait = LONG_HOLD;
				rx_calm = 0;
			end
			if (rx_wait > 0) begin
				rx_wait--;
				res_ready <= 1'b0;
			end else if (rx_calm > 0) begin
				rx_calm--;
				res_ready <= 1'b1;
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 3)
					rx_calm = $urandom_range(20, 60);
				else if (pick < 30)
					rx_wait = $urandom_range(0, 2);
				else if (pick < 36)
					rx_wait = $urandom_range(5, 25);
				res_ready <= (pick < 3) || (pick >= 36);
			end
		end
	end

	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((cmd_valid && cmd_ready) || (res_valid && res_ready)
					|| (psel && penable && pwrite && pready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	function automatic int unsigned sender_gap(bit calm);
		int pick;
		pick = $urandom_range(0, 99);
		if (calm || pick < 55)
			return 0;
		if (pick < 90)
			return $urandom_range(1, 3);
		return $urandom_range(6, 20);
	endfunction

	task automatic put_cmd(logic c, logic m, bit known, access_t r, int unsigned gap);
		known_access.push_back(typed_t'({known, r}));
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		command <= c;
		mask_bit <= m;
		do @(posedge clk); while (!cmd_ready);
	endtask

	// registers change only once every pending access has come out
	task automatic apb_write(reg_idx_t rsel, logic [63:0] value);
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (access_due.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'(int'(rsel) * APB_SLOT_BYTES);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	function automatic plan_t wr(reg_idx_t rsel, logic [63:0] value);
		plan_t p;
		p = '0;
		p.is_write = 1'b1;
		p.rsel = rsel;
		p.value = value;
		return p;
	endfunction

	function automatic plan_t cm(logic c, logic m);
		plan_t p;
		p = '0;
		p.cmd = c;
		p.mbit = m;
		return p;
	endfunction

	function automatic plan_t ck(logic c, logic m, logic [63:0] addr, int ridx, int nbytes,
			logic act, int elem, logic fin);
		plan_t p;
		p = cm(c, m);
		p.known = 1'b1;
		p.r = {addr, RIDX_W'(ridx), SIZE_W'(nbytes), act, ELEM_W'(elem), fin};
		return p;
	endfunction

	initial begin : stimulus
		plan_t directed[$];
		int unsigned phase, n, rand_items;
		int p;
		logic [7:0] vl;
		logic [6:0] st;
		logic [63:0] base;
		logic [15:0] stride;
		bit calm;
		logic c;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed = '{
			ck(CMD_ELEMENT, 1'b0, 64'h0, 0, 1, 1'b0, 0, 1'b1),
			ck(CMD_RESTART, 1'b1, 64'h0, 0, 1, 1'b0, 0, 1'b1),
			wr(REG_BASE_ADDRESS, 64'hFFFF_FFFF_FFFF_FFF8),
			wr(REG_ELEMENT_BYTES, 64'd8),
			wr(REG_VECTOR_LENGTH, 64'd128),
			wr(REG_FIRST_REGISTER, 64'd31),
			wr(REG_START_ELEMENT, 64'd127),
			wr(REG_UNMASKED, 64'd0),
			wr(REG_STRIDE, 64'h8000),
			wr(REG_EMUL_LOG2, 64'd4),
			ck(CMD_RESTART, 1'b0, 64'hFFFF_FFFF_FFFF_FFF8, 480, 8, 1'b0, 127, 1'b0),
			ck(CMD_ELEMENT, 1'b0, 64'hFFFF_FFFF_FFFF_FFF8, 480, 8, 1'b0, 127, 1'b0),
			cm(CMD_ELEMENT, 1'b1),
			wr(REG_STRIDE, 64'h7FFF),
			wr(REG_ELEMENT_BYTES, 64'hF),
			wr(REG_EMUL_LOG2, 64'd3),
			wr(REG_START_ELEMENT, 64'd0),
			wr(REG_VECTOR_LENGTH, 64'd255),
			cm(CMD_RESTART, 1'b0),
			cm(CMD_ELEMENT, 1'b1),
			cm(CMD_ELEMENT, 1'b0),
			cm(CMD_ELEMENT, 1'b1),
			wr(REG_ELEMENT_BYTES, 64'd0),
			wr(REG_UNMASKED, 64'd1),
			cm(CMD_ELEMENT, 1'b0),
			wr(REG_ELEMENT_BYTES, 64'd3),
			cm(CMD_ELEMENT, 1'b1),
			wr(REG_EMUL_LOG2, 64'd7),
			wr(REG_ELEMENT_BYTES, 64'd2),
			wr(REG_STRIDE, 64'd0),
			cm(CMD_RESTART, 1'b0),
			cm(CMD_ELEMENT, 1'b0),
			cm(CMD_ELEMENT, 1'b1),
			cm(CMD_ELEMENT, 1'b0),
			wr(REG_ELEMENT_BYTES, 64'd1),
			wr(REG_EMUL_LOG2, 64'd0),
			cm(CMD_RESTART, 1'b1),
			cm(CMD_ELEMENT, 1'b1),
			cm(CMD_ELEMENT, 1'b1),
			cm(CMD_ELEMENT, 1'b1),
			// slot now beyond the smaller register share
			wr(REG_ELEMENT_BYTES, 64'd8),
			cm(CMD_ELEMENT, 1'b0),
			cm(CMD_ELEMENT, 1'b1),
			wr(REG_START_ELEMENT, 64'd100),
			wr(REG_VECTOR_LENGTH, 64'd50),
			cm(CMD_RESTART, 1'b0),
			cm(CMD_ELEMENT, 1'b1)
		};

		foreach (directed[i]) begin
			if (directed[i].is_write)
				apb_write(directed[i].rsel, directed[i].value);
			else
				put_cmd(directed[i].cmd, directed[i].mbit, directed[i].known, directed[i].r,
					sender_gap(1'b0));
		end

		rand_items = 0;
		for (phase = 0; rand_items < RAND_ITEMS; phase++) begin
			p = $urandom_range(0, 7);
			base = (p == 0) ? '0 : (p == 1) ? '1 : {$urandom, $urandom};
			p = $urandom_range(0, 9);
			stride = (p == 0) ? 16'h7FFF : (p == 1) ? 16'h8000 : (p == 2) ? 16'hFFFF :
				(p < 6) ? 16'h0 : 16'($urandom);
			p = $urandom_range(0, 9);
			vl = (p == 0) ? 8'd0 : (p == 1) ? 8'd255 : (p == 2) ? 8'd128 :
				8'($urandom_range(1, 40));
			p = $urandom_range(0, 9);
			st = (p == 0) ? 7'd0 : (p == 1) ? 7'd127 :
				(vl == 0) ? 7'd0 : 7'($urandom_range(0, (vl > 128) ? 127 : vl - 1));

			if ($urandom_range(0, 9) < 7)
				apb_write(REG_BASE_ADDRESS, base);
			if ($urandom_range(0, 9) < 7)
				apb_write(REG_ELEMENT_BYTES, ($urandom_range(0, 9) < 8) ?
					64'(1 << $urandom_range(0, 3)) : 64'($urandom_range(0, 15)));
			if ($urandom_range(0, 9) < 7)
				apb_write(REG_FIRST_REGISTER, 64'($urandom_range(0, 31)));
			if ($urandom_range(0, 9) < 7)
				apb_write(REG_UNMASKED, 64'($urandom_range(0, 1)));
			if ($urandom_range(0, 9) < 7)
				apb_write(REG_STRIDE, 64'(stride));
			if ($urandom_range(0, 9) < 7)
				apb_write(REG_EMUL_LOG2, 64'($urandom_range(0, 7)));
			apb_write(REG_VECTOR_LENGTH, 64'(vl));
			apb_write(REG_START_ELEMENT, 64'(st));

			n = ((vl > st) ? vl - st : 0) + $urandom_range(1, 3);
			calm = ($urandom_range(0, 3) == 0);
			if (phase == 2 || phase == 25) begin
				hold_reqs <= hold_reqs + 1;
				calm = 1'b1;
				n += 8;
			end

			if ($urandom_range(0, 4) != 0) begin
				put_cmd(CMD_RESTART, 1'($urandom), 1'b0, '0, sender_gap(calm));
				rand_items++;
			end
			repeat (n) begin
				c = ($urandom_range(0, 24) == 0) ? CMD_RESTART : CMD_ELEMENT;
				put_cmd(c, 1'($urandom), 1'b0, '0, sender_gap(calm));
				rand_items++;
			end
		end

		cmd_valid <= 1'b0;
		@(posedge clk);
		while (access_due.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);

		$display("run: %0d commands, %0d results, %0d register writes, %0d random setups",
			commands_taken, results_seen, reg_writes, phase);
		$display("run: %0d active accesses, %0d finished, %0d mismatches",
			active_seen, finished_seen, mismatches);
		if (mismatches == 0 && access_due.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+rtl
rtl/vsag_pkg.sv
rtl/vector_strided_element_address_gen.sv
rtl/vsag_checker.sv
verif/tb.sv
